### rtl/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rfpw_pkg.sv
`timescale 1ns / 1ps

package rfpw_pkg;

   // Field widths
   localparam int CMD_W       = 2;
   localparam int POS_W       = 12;
   localparam int DIM_W       = 13;
   localparam int COLOR_W     = 24;
   localparam int PITCH_W     = 16;
   localparam int BPP_W       = 6;
   localparam int FMT_W       = 3;
   localparam int OFF_W       = 28;
   localparam int DATA_W      = 32;
   localparam int BE_W        = 4;
   localparam int CLAMP_W     = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 64;

   localparam int MAX_DIMENSION_DEF = 4096;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

   // Pixel formats
   localparam logic [FMT_W-1:0] FMT_UNKNOWN  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_BGRA8888 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_BGR888   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd4;
   localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_PITCH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BITS_PER_PIX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_READY  = 3'd5;

   // Byte enables
   localparam logic [BE_W-1:0] BE_32 = 4'hF;
   localparam logic [BE_W-1:0] BE_24 = 4'h7;
   localparam logic [BE_W-1:0] BE_16 = 4'h3;

   typedef struct packed {
      logic [DIM_W-1:0]   screen_width;
      logic [DIM_W-1:0]   screen_height;
      logic [PITCH_W-1:0] line_pitch;
      logic [BPP_W-1:0]   bits_per_pixel;
      logic [FMT_W-1:0]   pixel_format;
      logic               output_ready;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [DIM_W-1:0]   rect_width;
      logic [DIM_W-1:0]   rect_height;
      logic [COLOR_W-1:0] color;
   } item_type;

   typedef struct packed {
      logic [OFF_W-1:0]  byte_offset;
      logic [DATA_W-1:0] write_data;
      logic [BE_W-1:0]   byte_enable;
      logic              last_write;
   } wr_type;

   typedef struct packed {
      logic fill_busy;
   } status_type;

   // Bytes per pixel step; unknown formats step by three
   function automatic logic [2:0] fmt_step(input logic [FMT_W-1:0] f);
      logic [2:0] s;
      case (f)
         FMT_BGRA8888, FMT_RGBA8888: s = 3'd4;
         FMT_RGB565:                 s = 3'd2;
         default:                    s = 3'd3;
      endcase
      return s;
   endfunction

   function automatic logic [BE_W-1:0] fmt_enable(input logic [FMT_W-1:0] f);
      logic [BE_W-1:0] e;
      case (f)
         FMT_BGRA8888, FMT_RGBA8888: e = BE_32;
         FMT_RGB565:                 e = BE_16;
         default:                    e = BE_24;
      endcase
      return e;
   endfunction

   // 0xRRGGBB to native pixel bytes
   function automatic logic [DATA_W-1:0] pack_color(input logic [FMT_W-1:0] f,
                                                    input logic [COLOR_W-1:0] c);
      logic [7:0]        r;
      logic [7:0]        g;
      logic [7:0]        b;
      logic [DATA_W-1:0] d;
      r = c[23:16];
      g = c[15:8];
      b = c[7:0];
      case (f)
         FMT_BGRA8888: d = {8'hFF, r, g, b};
         FMT_RGBA8888: d = {r, g, b, 8'hFF};
         FMT_BGR888:   d = {8'h00, r, g, b};
         FMT_RGB888:   d = {8'h00, b, g, r};
         FMT_RGB565:   d = {16'h0000, r[7:3], g[7:2], b[7:3]};
         default:      d = '0;
      endcase
      return d;
   endfunction

endpackage

### rtl/rfpw_csr.sv
`timescale 1ns / 1ps

module rfpw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rfpw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfpw_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rfpw_pkg::cfg_type                cfg
);

   rfpw_pkg::cfg_type cfg_ff;
   rfpw_pkg::cfg_type cfg_in;

   // Register write decode; unmapped indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rfpw_pkg::REG_SCREEN_WIDTH:
               cfg_in.screen_width = csr_wdata[rfpw_pkg::DIM_W-1:0];
            rfpw_pkg::REG_SCREEN_HEIGHT:
               cfg_in.screen_height = csr_wdata[rfpw_pkg::DIM_W-1:0];
            rfpw_pkg::REG_LINE_PITCH:
               cfg_in.line_pitch = csr_wdata[rfpw_pkg::PITCH_W-1:0];
            rfpw_pkg::REG_BITS_PER_PIX:
               cfg_in.bits_per_pixel = csr_wdata[rfpw_pkg::BPP_W-1:0];
            rfpw_pkg::REG_PIXEL_FORMAT:
               cfg_in.pixel_format = csr_wdata[rfpw_pkg::FMT_W-1:0];
            rfpw_pkg::REG_OUTPUT_READY:
               cfg_in.output_ready = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/rfpw_engine.sv
`timescale 1ns / 1ps

module rfpw_engine #(
   parameter int MAX_DIMENSION = rfpw_pkg::MAX_DIMENSION_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rfpw_pkg::cfg_type    cfg,
   input  rfpw_pkg::item_type   item,
   input  logic                 item_valid,
   input  logic                 advance,
   output logic                 res_valid,
   output rfpw_pkg::wr_type     res,
   output rfpw_pkg::status_type status
);

   localparam int DW = rfpw_pkg::DIM_W;
   localparam int CW = rfpw_pkg::CLAMP_W;
   localparam int OW = rfpw_pkg::OFF_W;
   localparam logic [CW-1:0] MaxDim = CW'(MAX_DIMENSION);

   // Fill state
   logic                         busy_ff, busy_in;
   logic [DW-1:0]                col_ff, col_in;
   logic [DW-1:0]                row_ff, row_in;
   logic [DW-1:0]                cw_ff, cw_in;
   logic [DW-1:0]                ch_ff, ch_in;
   logic [OW-1:0]                rstart_ff, rstart_in;
   logic [rfpw_pkg::DATA_W-1:0]  packed_ff, packed_in;

   logic                         fire;
   logic [CW-1:0]                sw_raw, sh_raw, sw_eff, sh_eff;
   logic [CW-1:0]                x_ext, y_ext;
   logic                         off_screen;
   logic                         fmt_known;
   logic [2:0]                   step;
   logic [rfpw_pkg::BE_W-1:0]    enable;
   logic [3:0]                   bpc;
   logic [3:0]                   xfac;
   logic [OW-1:0]                y_prod;
   logic [15:0]                  x_prod;
   logic [OW-1:0]                pos_off;
   logic [15:0]                  col_prod;
   logic [DW:0]                  col_nx, row_nx;
   logic                         col_end, fill_last;
   logic [CW-1:0]                xw, yh;
   logic [DW-1:0]                w_clip, h_clip;

   assign fire = item_valid && advance;

   // Screen size clamped to the largest supported dimension
   always_comb begin
      sw_raw = CW'(cfg.screen_width);
      sh_raw = CW'(cfg.screen_height);
      sw_eff = (sw_raw > MaxDim) ? MaxDim : sw_raw;
      sh_eff = (sh_raw > MaxDim) ? MaxDim : sh_raw;
   end

   // Position offset: one 12x16 product plus a short x term
   always_comb begin
      x_ext      = CW'(item.pos_x);
      y_ext      = CW'(item.pos_y);
      off_screen = (x_ext >= sw_eff) || (y_ext >= sh_eff);
      fmt_known  = cfg.pixel_format inside {[rfpw_pkg::FMT_BGRA8888 : rfpw_pkg::FMT_RGB565]};
      step       = rfpw_pkg::fmt_step(cfg.pixel_format);
      enable     = rfpw_pkg::fmt_enable(cfg.pixel_format);
      bpc        = 4'((7'(cfg.bits_per_pixel) + 7'd7) >> 3);
      xfac       = (item.command == rfpw_pkg::CMD_FILL) ? bpc : {1'b0, step};
      y_prod     = OW'(item.pos_y) * OW'(cfg.line_pitch);
      x_prod     = 16'(item.pos_x) * 16'(xfac);
      pos_off    = y_prod + OW'(x_prod);
   end

   // Tick arithmetic
   always_comb begin
      col_prod  = 16'(col_ff) * 16'(step);
      col_nx    = (DW+1)'(col_ff) + 1'b1;
      row_nx    = (DW+1)'(row_ff) + 1'b1;
      col_end   = col_nx >= (DW+1)'(cw_ff);
      fill_last = col_end && (row_nx >= (DW+1)'(ch_ff));
   end

   // Rectangle clipping
   always_comb begin
      xw     = x_ext + CW'(item.rect_width);
      yh     = y_ext + CW'(item.rect_height);
      w_clip = (xw > sw_eff) ? DW'(sw_eff - x_ext) : item.rect_width;
      h_clip = (yh > sh_eff) ? DW'(sh_eff - y_ext) : item.rect_height;
   end

   // Command decode, result and next state
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      busy_in   = busy_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      cw_in     = cw_ff;
      ch_in     = ch_ff;
      rstart_in = rstart_ff;
      packed_in = packed_ff;
      case (item.command)
         rfpw_pkg::CMD_TICK: begin
            if (busy_ff) begin
               res_valid       = 1'b1;
               res.byte_offset = rstart_ff + OW'(col_prod);
               res.write_data  = packed_ff;
               res.byte_enable = enable;
               res.last_write  = fill_last;
               if (fill_last) begin
                  busy_in = 1'b0;
                  col_in  = '0;
                  row_in  = '0;
               end else if (col_end) begin
                  col_in    = '0;
                  row_in    = row_nx[DW-1:0];
                  rstart_in = rstart_ff + OW'(cfg.line_pitch);
               end else begin
                  col_in = col_nx[DW-1:0];
               end
            end
         end
         rfpw_pkg::CMD_PIXEL: begin
            if (cfg.output_ready && !busy_ff && !off_screen && fmt_known) begin
               res_valid       = 1'b1;
               res.byte_offset = pos_off;
               res.write_data  = rfpw_pkg::pack_color(cfg.pixel_format, item.color);
               res.byte_enable = enable;
               res.last_write  = 1'b1;
            end
         end
         rfpw_pkg::CMD_FILL: begin
            if (cfg.output_ready && !busy_ff && !off_screen &&
                (item.rect_width != '0) && (item.rect_height != '0)) begin
               busy_in   = 1'b1;
               col_in    = '0;
               row_in    = '0;
               cw_in     = w_clip;
               ch_in     = h_clip;
               rstart_in = pos_off;
               packed_in = rfpw_pkg::pack_color(cfg.pixel_format, item.color);
            end
         end
         default: ;
      endcase
      if (!item_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         cw_ff     <= '0;
         ch_ff     <= '0;
         rstart_ff <= '0;
         packed_ff <= '0;
      end else if (fire) begin
         busy_ff   <= busy_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cw_ff     <= cw_in;
         ch_ff     <= ch_in;
         rstart_ff <= rstart_in;
         packed_ff <= packed_in;
      end
   end

   assign status.fill_busy = busy_ff;

endmodule

### rtl/rect_fill_pixel_writer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser command, tdata geometry and colour
// rsp       out        rsp_tvalid/rsp_tready  tdata pixel write, tlast end of write run
// csr       in         csr_we                 csr_index, csr_wdata
//
// One request is taken per cycle unless a stalled rsp side holds the input register;
// each waits in the input register, where decode, clipping and the 12x16 offset
// product are worked out, then its write (if any) sits in the output register.
// Reset clears the fill state, the config registers and both valid flags.
// A stalled rsp side holds the output register; the input stage then holds too,
// and req_tready stays high only while the input register is empty.
`include "assert_macros.svh"

module rect_fill_pixel_writer #(
   parameter int MAX_DIMENSION = rfpw_pkg::MAX_DIMENSION_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request: tuser = command[1:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata = pos_x[11:0], pos_y[23:12], rect_width[36:24], rect_height[49:37],
   //         color[73:50], zero pad[79:74]
   input  logic [rfpw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [rfpw_pkg::CMD_W-1:0]        req_tuser,
   // Response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata = byte_offset[27:0], write_data[59:28], byte_enable[63:60]
   output logic [rfpw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   // Register writes
   input  logic                              csr_we,
   input  logic [rfpw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfpw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rfpw_pkg::cfg_type    cfg;
   rfpw_pkg::item_type   req_item;
   rfpw_pkg::wr_type     eng_res;
   rfpw_pkg::status_type eng_status;
   logic                 eng_res_valid;

   logic                 in_valid_ff, in_valid_in;
   rfpw_pkg::item_type   in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   rfpw_pkg::wr_type     out_wr_ff;
   logic                 advance;
   logic                 req_fire;

   // Request unpacking
   always_comb begin
      req_item.command     = req_tuser;
      req_item.pos_x       = req_tdata[11:0];
      req_item.pos_y       = req_tdata[23:12];
      req_item.rect_width  = req_tdata[36:24];
      req_item.rect_height = req_tdata[49:37];
      req_item.color       = req_tdata[73:50];
   end

   // Input stage moves on whenever the output register is free or draining
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = advance ? (in_valid_ff && eng_res_valid) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance && in_valid_ff && eng_res_valid) begin
         out_wr_ff <= eng_res;
      end
   end

   rfpw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfpw_engine #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (in_item_ff),
      .item_valid (in_valid_ff),
      .advance    (advance),
      .res_valid  (eng_res_valid),
      .res        (eng_res),
      .status     (eng_status)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_wr_ff.byte_enable, out_wr_ff.write_data, out_wr_ff.byte_offset};
   assign rsp_tlast  = out_wr_ff.last_write;

   // Checks
   `ASSERT_IMP(a_be_legal, clock, reset, out_valid_ff, (out_wr_ff.byte_enable == rfpw_pkg::BE_32) || (out_wr_ff.byte_enable == rfpw_pkg::BE_24) || (out_wr_ff.byte_enable == rfpw_pkg::BE_16), "illegal byte enable on response")
   `ASSERT_IMP(a_mid_fill_busy, clock, reset, in_valid_ff && eng_res_valid && !eng_res.last_write, eng_status.fill_busy, "non-final write outside a fill")
   `ASSERT_NXT(a_last_ends_fill, clock, reset, in_valid_ff && advance && eng_res_valid && eng_res.last_write && (in_item_ff.command == rfpw_pkg::CMD_TICK), !eng_status.fill_busy, "fill still busy after its final write")
   `ASSERT_IMP(a_ready_when_free, clock, reset, !out_valid_ff, req_tready, "request refused with output register free")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [rfpw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned OFF_MASK        = 32'h0FFF_FFFF;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned TARGET_REQUESTS = 1600;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned MAX_REPORTS     = 50;

   // Predicts pixel writes from accepted requests and checks the write stream
   class pixel_write_checker;
      logic [rfpw_pkg::DIM_W-1:0]   scr_width;
      logic [rfpw_pkg::DIM_W-1:0]   scr_height;
      logic [rfpw_pkg::PITCH_W-1:0] pitch;
      logic [rfpw_pkg::BPP_W-1:0]   bpp;
      logic [rfpw_pkg::FMT_W-1:0]   fmt;
      logic                         ready;
      bit                           fill_busy;
      int unsigned                  col;
      int unsigned                  row;
      int unsigned                  clip_w;
      int unsigned                  clip_h;
      int unsigned                  row_base;
      logic [rfpw_pkg::DATA_W-1:0]  fill_pixel;
      rfpw_pkg::wr_type             expected_writes[$];
      int unsigned                  errors;

      function new();
         scr_width  = '0;
         scr_height = '0;
         pitch      = '0;
         bpp        = '0;
         fmt        = rfpw_pkg::FMT_UNKNOWN;
         ready      = 1'b0;
         fill_busy  = 1'b0;
         col        = 0;
         row        = 0;
         clip_w     = 0;
         clip_h     = 0;
         row_base   = 0;
         fill_pixel = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [rfpw_pkg::CSR_IDX_W-1:0] idx,
                            logic [rfpw_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            rfpw_pkg::REG_SCREEN_WIDTH:  scr_width  = val[rfpw_pkg::DIM_W-1:0];
            rfpw_pkg::REG_SCREEN_HEIGHT: scr_height = val[rfpw_pkg::DIM_W-1:0];
            rfpw_pkg::REG_LINE_PITCH:    pitch      = val[rfpw_pkg::PITCH_W-1:0];
            rfpw_pkg::REG_BITS_PER_PIX:  bpp        = val[rfpw_pkg::BPP_W-1:0];
            rfpw_pkg::REG_PIXEL_FORMAT:  fmt        = val[rfpw_pkg::FMT_W-1:0];
            rfpw_pkg::REG_OUTPUT_READY:  ready      = val[0];
            default: ;
         endcase
      endfunction

      // screen sizes past the maximum count as the maximum
      function int unsigned clamp_dim(logic [rfpw_pkg::DIM_W-1:0] d);
         int unsigned v;
         v = 32'(d);
         return (v > rfpw_pkg::MAX_DIMENSION_DEF) ? rfpw_pkg::MAX_DIMENSION_DEF : v;
      endfunction

      function int unsigned step_bytes(logic [rfpw_pkg::FMT_W-1:0] f);
         case (f)
            rfpw_pkg::FMT_BGRA8888, rfpw_pkg::FMT_RGBA8888: return 4;
            rfpw_pkg::FMT_RGB565:                           return 2;
            default:                                        return 3;
         endcase
      endfunction

      function logic [rfpw_pkg::BE_W-1:0] lane_mask(logic [rfpw_pkg::FMT_W-1:0] f);
         case (f)
            rfpw_pkg::FMT_BGRA8888, rfpw_pkg::FMT_RGBA8888: return 4'b1111;
            rfpw_pkg::FMT_RGB565:                           return 4'b0011;
            default:                                        return 4'b0111;
         endcase
      endfunction

      // 0xRRGGBB to native bytes, first byte lowest
      function logic [rfpw_pkg::DATA_W-1:0] native_pixel(logic [rfpw_pkg::FMT_W-1:0] f,
                                                         logic [rfpw_pkg::COLOR_W-1:0] c);
         case (f)
            rfpw_pkg::FMT_BGRA8888: return {8'hFF, c};
            rfpw_pkg::FMT_RGBA8888: return {c, 8'hFF};
            rfpw_pkg::FMT_BGR888:   return {8'h00, c};
            rfpw_pkg::FMT_RGB888:   return {8'h00, c[7:0], c[15:8], c[23:16]};
            rfpw_pkg::FMT_RGB565:   return {16'h0000, c[23:19], c[15:10], c[7:3]};
            default:                return '0;
         endcase
      endfunction

      // Returns 1 when the request writes a pixel or arms a fill
      function bit note_request(rfpw_pkg::item_type it);
         int unsigned      sw;
         int unsigned      sh;
         int unsigned      x;
         int unsigned      y;
         int unsigned      w;
         int unsigned      h;
         int unsigned      bytes_pp;
         int unsigned      off;
         bit               known;
         rfpw_pkg::wr_type wr;
         sw = clamp_dim(scr_width);
         sh = clamp_dim(scr_height);
         x  = 32'(it.pos_x);
         y  = 32'(it.pos_y);
         w  = 32'(it.rect_width);
         h  = 32'(it.rect_height);
         known = (fmt >= rfpw_pkg::FMT_BGRA8888) && (fmt <= rfpw_pkg::FMT_RGB565);

         // fill tick: step size and lanes follow the live registers
         if (it.command == rfpw_pkg::CMD_TICK) begin
            if (!fill_busy) return 1'b0;
            off            = (row_base + col * step_bytes(fmt)) & OFF_MASK;
            wr.byte_offset = off[rfpw_pkg::OFF_W-1:0];
            wr.write_data  = fill_pixel;
            wr.byte_enable = lane_mask(fmt);
            wr.last_write  = (col + 1 >= clip_w) && (row + 1 >= clip_h);
            expected_writes.push_back(wr);
            if (wr.last_write) begin
               fill_busy = 1'b0;
               col = 0;
               row = 0;
            end else if (col + 1 >= clip_w) begin
               col = 0;
               row = (row + 1) & 32'h1FFF;
               row_base = (row_base + 32'(pitch)) & OFF_MASK;
            end else begin
               col = (col + 1) & 32'h1FFF;
            end
            return 1'b1;
         end

         if (it.command == CMD_UNUSED || !ready || fill_busy) return 1'b0;

         if (it.command == rfpw_pkg::CMD_PIXEL) begin
            if (x >= sw || y >= sh || !known) return 1'b0;
            off            = (y * 32'(pitch) + x * step_bytes(fmt)) & OFF_MASK;
            wr.byte_offset = off[rfpw_pkg::OFF_W-1:0];
            wr.write_data  = native_pixel(fmt, it.color);
            wr.byte_enable = lane_mask(fmt);
            wr.last_write  = 1'b1;
            expected_writes.push_back(wr);
            return 1'b1;
         end

         // fill: clip to the screen and latch the colour
         if (w == 0 || h == 0 || x >= sw || y >= sh) return 1'b0;
         if (x + w > sw) w = sw - x;
         if (y + h > sh) h = sh - y;
         bytes_pp   = (32'(bpp) + 7) >> 3;
         clip_w     = w;
         clip_h     = h;
         col        = 0;
         row        = 0;
         row_base   = (y * 32'(pitch) + x * bytes_pp) & OFF_MASK;
         fill_pixel = native_pixel(fmt, it.color);
         fill_busy  = 1'b1;
         return 1'b1;
      endfunction

      function void check_write(logic [rfpw_pkg::RSP_TDATA_W-1:0] d, logic lst);
         rfpw_pkg::wr_type             want;
         logic [rfpw_pkg::OFF_W-1:0]   got_off;
         logic [rfpw_pkg::DATA_W-1:0]  got_data;
         logic [rfpw_pkg::BE_W-1:0]    got_be;
         got_off  = d[rfpw_pkg::OFF_W-1:0];
         got_data = d[rfpw_pkg::OFF_W+rfpw_pkg::DATA_W-1:rfpw_pkg::OFF_W];
         got_be   = d[rfpw_pkg::RSP_TDATA_W-1:rfpw_pkg::OFF_W+rfpw_pkg::DATA_W];
         if (expected_writes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected write, expected none, %s %h data %h be %h last %b",
                        $time, "actual offset", got_off, got_data, got_be, lst);
            return;
         end
         want = expected_writes.pop_front();
         if (got_off !== want.byte_offset) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: byte_offset expected %h actual %h", $time,
                        want.byte_offset, got_off);
         end
         if (got_data !== want.write_data) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: write_data expected %h actual %h", $time,
                        want.write_data, got_data);
         end
         if (got_be !== want.byte_enable) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: byte_enable expected %h actual %h", $time,
                        want.byte_enable, got_be);
         end
         if (lst !== want.last_write) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: last_write expected %b actual %b", $time,
                        want.last_write, lst);
         end
      endfunction

      function int unsigned pending();
         return expected_writes.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rfpw_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [rfpw_pkg::CMD_W-1:0]       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rfpw_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_we;
   logic [rfpw_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [rfpw_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pixel_write_checker sb = new();

   int unsigned sent_count   = 0;
   int unsigned burst_left   = 0;
   int unsigned stall_mode   = 0;
   int unsigned mode_left    = 0;
   int unsigned stall_phase  = 0;
   int unsigned cycle_count  = 0;

   rect_fill_pixel_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Write monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_write(rsp_tdata, rsp_tlast);
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      stall_phase++;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((stall_phase % 5) < 2);
      endcase
   end

   function automatic rfpw_pkg::item_type make_item(logic [rfpw_pkg::CMD_W-1:0] cmd,
                                                    int unsigned x, int unsigned y,
                                                    int unsigned w, int unsigned h,
                                                    logic [rfpw_pkg::COLOR_W-1:0] c);
      rfpw_pkg::item_type it;
      it.command     = cmd;
      it.pos_x       = 12'(x);
      it.pos_y       = 12'(y);
      it.rect_width  = 13'(w);
      it.rect_height = 13'(h);
      it.color       = c;
      return it;
   endfunction

   // Send one request; the sender pauses between bursts
   task automatic issue(rfpw_pkg::item_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= it.command;
      req_tdata  <= {6'b0, it.color, it.rect_height, it.rect_width, it.pos_y, it.pos_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      void'(sb.note_request(it));
      sent_count++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   // Wait for every predicted write, then let the pipeline settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [rfpw_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[rfpw_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      sb.set_reg(idx, val[rfpw_pkg::CSR_DATA_W-1:0]);
   endtask

   task automatic apply_config(int unsigned sw, int unsigned sh, int unsigned pitch,
                               int unsigned bpp, int unsigned fmt, int unsigned rdy);
      wait_drained();
      write_reg(rfpw_pkg::REG_SCREEN_WIDTH, sw);
      write_reg(rfpw_pkg::REG_SCREEN_HEIGHT, sh);
      write_reg(rfpw_pkg::REG_LINE_PITCH, pitch);
      write_reg(rfpw_pkg::REG_BITS_PER_PIX, bpp);
      write_reg(rfpw_pkg::REG_PIXEL_FORMAT, fmt);
      write_reg(rfpw_pkg::REG_OUTPUT_READY, rdy);
      csr_we <= 1'b0;
   endtask

   // Mostly small screens so fills stay short; sometimes the extremes
   function automatic int unsigned pick_dim_reg();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 8191;
         2:       return rfpw_pkg::MAX_DIMENSION_DEF;
         3:       return $urandom_range(rfpw_pkg::MAX_DIMENSION_DEF + 1, 8190);
         4:       return $urandom_range(17, rfpw_pkg::MAX_DIMENSION_DEF - 1);
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   // On large screens stay near the far edge so clipped fills are small
   function automatic int unsigned near_edge(int unsigned eff);
      int unsigned v;
      if (eff == 0) return $urandom_range(0, 4095);
      if (eff <= 16) return $urandom_range(0, eff);
      v = eff - $urandom_range(0, 16);
      return (v > 4095) ? 4095 : v;
   endfunction

   function automatic rfpw_pkg::item_type random_item();
      rfpw_pkg::item_type it;
      int unsigned        pick;
      int unsigned        sw;
      int unsigned        sh;
      it.pos_x       = 12'($urandom);
      it.pos_y       = 12'($urandom);
      it.rect_width  = 13'($urandom);
      it.rect_height = 13'($urandom);
      it.color       = 24'($urandom);
      sw   = sb.clamp_dim(sb.scr_width);
      sh   = sb.clamp_dim(sb.scr_height);
      pick = $urandom_range(0, 99);
      // while filling, mostly ticks with some dropped commands mixed in
      if (sb.fill_busy)
         it.command = (pick < 88) ? rfpw_pkg::CMD_TICK :
                      (pick < 93) ? rfpw_pkg::CMD_PIXEL :
                      (pick < 97) ? rfpw_pkg::CMD_FILL : CMD_UNUSED;
      else
         it.command = (pick < 50) ? rfpw_pkg::CMD_FILL :
                      (pick < 85) ? rfpw_pkg::CMD_PIXEL :
                      (pick < 93) ? rfpw_pkg::CMD_TICK : CMD_UNUSED;
      if (it.command == rfpw_pkg::CMD_PIXEL && $urandom_range(0, 3) != 0) begin
         it.pos_x = 12'(near_edge(sw));
         it.pos_y = 12'(near_edge(sh));
      end
      if (it.command == rfpw_pkg::CMD_FILL) begin
         it.pos_x = 12'(near_edge(sw));
         it.pos_y = 12'(near_edge(sh));
         case ($urandom_range(0, 19))
            0:       it.rect_width = '0;
            1, 2, 3: it.rect_width = 13'($urandom);
            default: it.rect_width = 13'($urandom_range(1, 20));
         endcase
         case ($urandom_range(0, 19))
            0:       it.rect_height = '0;
            1, 2, 3: it.rect_height = 13'($urandom);
            default: it.rect_height = 13'($urandom_range(1, 20));
         endcase
      end
      return it;
   endfunction

   initial begin
      int unsigned pitch;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= rfpw_pkg::CMD_TICK;
      csr_we     <= 1'b0;
      csr_index  <= rfpw_pkg::REG_SCREEN_WIDTH;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: output not ready, everything dropped
      issue(make_item(rfpw_pkg::CMD_PIXEL, 0, 0, 1, 1, 24'hFFFFFF));
      issue(make_item(rfpw_pkg::CMD_FILL, 0, 0, 1, 1, 24'hFFFFFF));
      issue(make_item(rfpw_pkg::CMD_TICK, 0, 0, 0, 0, 24'h000000));
      issue(make_item(CMD_UNUSED, 4095, 4095, 8191, 8191, 24'hFFFFFF));

      // Oversized screen clamps; extreme positions, pitch and depth
      apply_config(8191, 8191, 65535, 63, 32'(rfpw_pkg::FMT_BGRA8888), 1);
      issue(make_item(rfpw_pkg::CMD_PIXEL, 4095, 4095, 0, 0, 24'hFFFFFF));
      issue(make_item(rfpw_pkg::CMD_PIXEL, 0, 0, 8191, 8191, 24'h000000));
      issue(make_item(rfpw_pkg::CMD_FILL, 4095, 4095, 8191, 8191, 24'h123456));
      issue(make_item(rfpw_pkg::CMD_PIXEL, 1, 1, 0, 0, 24'hABCDEF));
      issue(make_item(rfpw_pkg::CMD_FILL, 0, 0, 2, 2, 24'hABCDEF));
      issue(make_item(rfpw_pkg::CMD_TICK, 0, 0, 0, 0, 24'h000000));
      issue(make_item(rfpw_pkg::CMD_TICK, 0, 0, 0, 0, 24'h000000));
      issue(make_item(rfpw_pkg::CMD_FILL, 0, 0, 0, 5, 24'h555555));
      issue(make_item(rfpw_pkg::CMD_FILL, 0, 0, 5, 0, 24'h555555));

      // Registers changed during a fill, including output ready falling
      apply_config(4, 2, 100, 32, 32'(rfpw_pkg::FMT_BGRA8888), 1);
      issue(make_item(rfpw_pkg::CMD_FILL, 1, 0, 8191, 8191, 24'hAABBCC));
      issue(make_item(rfpw_pkg::CMD_TICK, 0, 0, 0, 0, 24'h000000));
      issue(make_item(rfpw_pkg::CMD_TICK, 0, 0, 0, 0, 24'h000000));
      apply_config(4, 2, 40, 16, 32'(rfpw_pkg::FMT_RGB565), 0);
      repeat (4) issue(make_item(rfpw_pkg::CMD_TICK, 0, 0, 0, 0, 24'h000000));
      issue(make_item(rfpw_pkg::CMD_PIXEL, 0, 0, 0, 0, 24'hAABBCC));

      // Single pixel in every format code, unknown ones included
      for (int f = 0; f < 8; f++) begin
         apply_config(16, 16, 64, 24, f, 1);
         issue(make_item(rfpw_pkg::CMD_PIXEL, 15, 15, 0, 0, 24'($urandom)));
      end

      // Random phases, each under a fresh register setting
      while (sent_count < TARGET_REQUESTS) begin
         pitch = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 65535 : 0)
                                             : $urandom_range(0, 65535);
         apply_config(pick_dim_reg(), pick_dim_reg(), pitch, $urandom_range(0, 63),
                      $urandom_range(0, 7), ($urandom_range(0, 7) != 0) ? 1 : 0);
         repeat ($urandom_range(20, 80)) issue(random_item());
      end

      wait_drained();
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/rfpw_pkg.sv
rtl/rfpw_csr.sv
rtl/rfpw_engine.sv
rtl/rect_fill_pixel_writer.sv
test/tb_top.sv
